// File: hdl/dplc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dplc_pkg
// Shared types, codes and helpers of the debounced presence lid controller.
// ----------------------------------------------------------------------------
package dplc_pkg;

  typedef enum logic [1:0] {
    LID_CLOSED  = 2'd0,
    LID_OPENING = 2'd1,
    LID_OPEN    = 2'd2,
    LID_CLOSING = 2'd3
  } lid_state_t;

  typedef enum logic [2:0] {
    EV_NONE          = 3'd0,
    EV_OPENING       = 3'd1,
    EV_OPENED        = 3'd2,
    EV_CLOSE_TIMEOUT = 3'd3,
    EV_CLOSE_ABSENCE = 3'd4,
    EV_CLOSED        = 3'd5
  } lid_event_t;

  typedef enum logic [2:0] {
    CFG_ACTIVE_LEVEL   = 3'd0,
    CFG_DEBOUNCE_TIME  = 3'd1,
    CFG_TRAVEL_TIME    = 3'd2,
    CFG_MAX_OPEN_TIME  = 3'd3,
    CFG_HOLD_OPEN_TIME = 3'd4,
    CFG_OPEN_ANGLE     = 3'd5,
    CFG_CLOSED_ANGLE   = 3'd6
  } cfg_index_t;

  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [7:0]  ANGLE_MAX  = 8'd180;

  function automatic logic [7:0] sat_angle(input logic [7:0] angle);
    sat_angle = (angle > ANGLE_MAX) ? ANGLE_MAX : angle;
  endfunction

endpackage
`default_nettype wire

// File: hdl/dplc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dplc_in_if
// Poll channel: one beat carries a raw sensor sample and its timestamp.
// ----------------------------------------------------------------------------
interface dplc_in_if;
  logic        valid;
  logic        ready;
  logic        raw_sample;
  logic [31:0] now_ms;

  modport source (output valid, raw_sample, now_ms, input ready);
  modport sink   (input valid, raw_sample, now_ms, output ready);
endinterface
`default_nettype wire

// File: hdl/dplc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dplc_out_if
// Result channel: one beat carries the lid status after one poll.
// ----------------------------------------------------------------------------
interface dplc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] lid_state;
  logic       servo_enable;
  logic [7:0] servo_angle;
  logic       presence;
  logic [2:0] event_res;

  modport source (output valid, lid_state, servo_enable, servo_angle, presence, event_res,
                  input ready);
  modport sink   (input valid, lid_state, servo_enable, servo_angle, presence, event_res,
                  output ready);
endinterface
`default_nettype wire

// File: hdl/dplc_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dplc_cfg_if
// Configuration write channel: one beat writes one register.
// ----------------------------------------------------------------------------
interface dplc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    index;
  logic [dplc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/debounced_presence_lid_controller.sv
`default_nettype none
// A poll is held in the input register and its result in the result register.
// Throughput: one poll per cycle; the input register feeds the state update directly.
// A stalled result register holds the pipeline; the input register keeps one beat.
// Reset (synchronous, active low) restores register defaults, a closed lid and a
// released servo; configuration writes are always accepted but ignored in reset.
// ----------------------------------------------------------------------------
// debounced_presence_lid_controller
// Debounces a presence sensor and runs the closed/opening/open/closing lid
// machine on modular 32-bit millisecond timestamps.
// ----------------------------------------------------------------------------
module debounced_presence_lid_controller (
  input  wire         clk,
  input  wire         rst_n,
  dplc_in_if.sink     in_ch,
  dplc_out_if.source  out_ch,
  dplc_cfg_if.sink    cfg_ch
);
  import dplc_pkg::*;

  logic        active_level_r;
  logic [15:0] debounce_time_r;
  logic [15:0] travel_time_r;
  logic [23:0] max_open_time_r;
  logic [23:0] hold_open_time_r;
  logic [7:0]  open_angle_r;
  logic [7:0]  closed_angle_r;

  logic        s1_valid_r;
  logic        s1_raw_r;
  logic [31:0] s1_now_r;

  lid_state_t  mode_r, mode_nxt;
  logic [31:0] mode_entered_r, mode_entered_nxt;
  logic [31:0] opened_time_r, opened_time_nxt;
  logic [31:0] last_seen_r, last_seen_nxt;
  logic        stable_r, stable_nxt;
  logic        prev_raw_r, prev_raw_nxt;
  logic [31:0] raw_change_r, raw_change_nxt;
  logic [7:0]  angle_r, angle_nxt;
  logic        driving_r, driving_nxt;
  lid_event_t  event_nxt;

  logic        out_valid_r;
  lid_state_t  out_state_r;
  logic        out_enable_r;
  logic [7:0]  out_angle_r;
  logic        out_presence_r;
  lid_event_t  out_event_r;

  logic        adv;
  logic        fire;
  logic        raw;
  logic [31:0] d_raw, d_mode, d_opened, d_seen;
  logic        debounced, travel_done, open_timeout, absence_done;

  assign adv          = !out_valid_r || out_ch.ready;
  assign fire         = s1_valid_r && adv;
  assign in_ch.ready  = !s1_valid_r || adv;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_level_r   <= 1'b0;
      debounce_time_r  <= 16'd50;
      travel_time_r    <= 16'd600;
      max_open_time_r  <= 24'd30000;
      hold_open_time_r <= 24'd3000;
      open_angle_r     <= 8'd90;
      closed_angle_r   <= 8'd0;
    end else if (cfg_ch.valid) begin
      case (cfg_index_t'(cfg_ch.index))
        CFG_ACTIVE_LEVEL:   active_level_r   <= cfg_ch.data[0];
        CFG_DEBOUNCE_TIME:  debounce_time_r  <= cfg_ch.data[15:0];
        CFG_TRAVEL_TIME:    travel_time_r    <= cfg_ch.data[15:0];
        CFG_MAX_OPEN_TIME:  max_open_time_r  <= cfg_ch.data[23:0];
        CFG_HOLD_OPEN_TIME: hold_open_time_r <= cfg_ch.data[23:0];
        CFG_OPEN_ANGLE:     open_angle_r     <= cfg_ch.data[7:0];
        CFG_CLOSED_ANGLE:   closed_angle_r   <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_raw_r <= in_ch.raw_sample;
      s1_now_r <= in_ch.now_ms;
    end
  end

  // Debounce and timestamp differences, all modulo 2^32.
  always_comb begin
    raw            = (s1_raw_r == active_level_r);
    prev_raw_nxt   = prev_raw_r;
    raw_change_nxt = raw_change_r;
    stable_nxt     = stable_r;
    d_raw          = s1_now_r - raw_change_r;
    debounced      = (d_raw >= {16'd0, debounce_time_r});
    if (raw != prev_raw_r) begin
      prev_raw_nxt   = raw;
      raw_change_nxt = s1_now_r;
    end else if (raw != stable_r && debounced) begin
      stable_nxt = raw;
    end
    last_seen_nxt = stable_nxt ? s1_now_r : last_seen_r;
    d_mode        = s1_now_r - mode_entered_r;
    d_opened      = s1_now_r - opened_time_r;
    d_seen        = s1_now_r - last_seen_r;
    travel_done   = (d_mode >= {16'd0, travel_time_r});
    open_timeout  = (d_opened >= {8'd0, max_open_time_r});
    absence_done  = !stable_nxt && (d_seen >= {8'd0, hold_open_time_r});
  end

  // Next state of the lid machine.
  always_comb begin
    mode_nxt = mode_r;
    case (mode_r)
      LID_CLOSED:  if (stable_nxt) mode_nxt = LID_OPENING;
      LID_OPENING: if (travel_done) mode_nxt = LID_OPEN;
      LID_OPEN:    if (open_timeout || absence_done) mode_nxt = LID_CLOSING;
      LID_CLOSING: if (travel_done) mode_nxt = LID_CLOSED;
      default:     mode_nxt = LID_CLOSED;
    endcase
  end

  // Outputs of the lid machine: event code, servo drive and timestamps.
  always_comb begin
    event_nxt        = EV_NONE;
    angle_nxt        = angle_r;
    driving_nxt      = driving_r;
    opened_time_nxt  = opened_time_r;
    mode_entered_nxt = (mode_nxt != mode_r) ? s1_now_r : mode_entered_r;
    case (mode_r)
      LID_CLOSED: begin
        if (stable_nxt) begin
          event_nxt   = EV_OPENING;
          angle_nxt   = sat_angle(open_angle_r);
          driving_nxt = 1'b1;
        end
      end
      LID_OPENING: begin
        if (travel_done) begin
          event_nxt       = EV_OPENED;
          driving_nxt     = 1'b0;
          opened_time_nxt = s1_now_r;
        end
      end
      LID_OPEN: begin
        if (open_timeout || absence_done) begin
          event_nxt   = open_timeout ? EV_CLOSE_TIMEOUT : EV_CLOSE_ABSENCE;
          angle_nxt   = sat_angle(closed_angle_r);
          driving_nxt = 1'b1;
        end
      end
      LID_CLOSING: begin
        if (travel_done) begin
          event_nxt   = EV_CLOSED;
          driving_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= LID_CLOSED;
      mode_entered_r <= 32'd0;
      opened_time_r  <= 32'd0;
      last_seen_r    <= 32'd0;
      stable_r       <= 1'b0;
      prev_raw_r     <= 1'b0;
      raw_change_r   <= 32'd0;
      angle_r        <= 8'd0;
      driving_r      <= 1'b0;
    end else if (fire) begin
      mode_r         <= mode_nxt;
      mode_entered_r <= mode_entered_nxt;
      opened_time_r  <= opened_time_nxt;
      last_seen_r    <= last_seen_nxt;
      stable_r       <= stable_nxt;
      prev_raw_r     <= prev_raw_nxt;
      raw_change_r   <= raw_change_nxt;
      angle_r        <= angle_nxt;
      driving_r      <= driving_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_state_r    <= mode_nxt;
      out_enable_r   <= driving_nxt;
      out_angle_r    <= angle_nxt;
      out_presence_r <= stable_nxt;
      out_event_r    <= event_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.lid_state    = out_state_r;
  assign out_ch.servo_enable = out_enable_r;
  assign out_ch.servo_angle  = out_angle_r;
  assign out_ch.presence     = out_presence_r;
  assign out_ch.event_res    = out_event_r;

  // The servo is driven exactly while the lid is moving.
  a_drive_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_enable_r == (out_state_r == LID_OPENING ||
                                      out_state_r == LID_CLOSING)))
    else $error("servo enable does not match lid motion");

  // A closing event always leaves the lid in the closing state.
  a_close_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_event_r == EV_CLOSE_TIMEOUT || out_event_r == EV_CLOSE_ABSENCE))
    |-> (out_state_r == LID_CLOSING))
    else $error("closing event without closing state");

  // An opened event leaves the lid open with the servo released.
  a_opened_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_r == EV_OPENED) |-> (out_state_r == LID_OPEN && !out_enable_r))
    else $error("opened event with wrong lid status");

  // The lid state only moves when a poll is processed.
  a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(mode_r))
    else $error("lid state changed without a poll");

endmodule
`default_nettype wire
